>>> design/cvg_pkg.sv
// Shared types, constants and rounding helpers of the capsule vertex generator.
package cvg_pkg;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_CFG     = 2'd1;
  localparam logic [1:0] ST_OUT_OF_GRID = 2'd2;

  localparam logic [1:0] REG_HEIGHT  = 2'd0;
  localparam logic [1:0] REG_RADIUS  = 2'd1;
  localparam logic [1:0] REG_COLUMNS = 2'd2;
  localparam logic [1:0] REG_RINGS   = 2'd3;

  // Q30 Taylor terms of sin(pi/2*x), applied innermost first
  localparam logic [30:0] SIN_C9 = 31'd172272;
  localparam logic [30:0] SIN_COEF [4] = '{31'd5026995, 31'd85569306,
                                           31'd693598668, 31'd1686629713};
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // fold, square, four Horner steps, final product, sign
  localparam int SINE_LAT = 8;

  typedef struct packed {
    logic [1:0] st;
    logic       plo;   // bottom pole
    logic       phi;   // top pole
    logic       bot;   // bottom hemisphere
  } side_t;

  // round half away from zero, then shift right by sh
  function automatic logic signed [63:0] rnd_away(input logic signed [63:0] v,
                                                  input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [16:0] sat17(input logic signed [63:0] v);
    if (v > 64'sd65535) return 17'sd65535;
    if (v < -64'sd65536) return -17'sd65536;
    return v[16:0];
  endfunction

endpackage

>>> design/cvg_delay.sv
// Resettable shift line that carries sideband bits beside a pipeline.
module cvg_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) sr_r[k] <= '0;
    end else if (en) begin
      sr_r[0] <= din;
      for (int k = 1; k < DEPTH; k++) sr_r[k] <= sr_r[k-1];
    end
  end

  assign dout = sr_r[DEPTH-1];
endmodule

>>> design/cvg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cvg_div #(
  parameter int NW = 26,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,   // held steady while words are in flight
  output logic [NW-1:0] quo
);
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] n_r   [NW];
  logic [NW-1:0] q_r   [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [DW:0]   trial;
    logic          qbit;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign n_in   = num;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign n_in   = n_r[k-1];
      assign q_in   = q_r[k-1];
    end
    assign trial = {rem_in, n_in[NW-1]};
    assign qbit  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= qbit ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        n_r[k]   <= n_in << 1;
        q_r[k]   <= {q_in[NW-2:0], qbit};
      end
    end
  end

  assign quo = q_r[NW-1];
endmodule

>>> design/cvg_sine.sv
// Pipelined sine of a phase word: quadrant fold and a Q30 odd polynomial.
module cvg_sine #(
  parameter int AB = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [AB-1:0]      phase,
  output logic signed [31:0] sine
);
  import cvg_pkg::*;

  localparam int QB = AB - 2;

  logic [30:0]        x_r  [6];
  logic               n_r  [7];
  logic [30:0]        x2_r [4];
  logic [30:0]        t_r  [4];
  logic [30:0]        f_r;
  logic signed [31:0] sine_r;
  logic [30:0]        x_fold;
  logic [61:0]        sq;
  logic [61:0]        fp;

  always_comb begin
    x_fold = 31'(phase[QB-1:0]) << (30 - QB);
    if (phase[QB]) x_fold = ONE_Q30 - x_fold;
  end

  assign sq = 62'(x_r[0]) * 62'(x_r[0]);
  assign fp = 62'(x_r[5]) * 62'(t_r[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x_fold;
      n_r[0]  <= phase[AB-1];
      x2_r[0] <= sq[60:30];
      x_r[1]  <= x_r[0];
      n_r[1]  <= n_r[0];
      f_r     <= (fp[60:30] > ONE_Q30) ? ONE_Q30 : fp[60:30];
      n_r[6]  <= n_r[5];
      sine_r  <= n_r[6] ? -$signed({1'b0, f_r}) : $signed({1'b0, f_r});
    end
  end

  // Horner steps: t = C - x2*t
  for (genvar m = 0; m < 4; m++) begin : g_horner
    logic [30:0] t_in;
    logic [61:0] p;
    if (m == 0) begin : g_first
      assign t_in = SIN_C9;
    end else begin : g_next
      assign t_in = t_r[m-1];
    end
    assign p = 62'(x2_r[m]) * 62'(t_in);
    always_ff @(posedge clk) begin
      if (en) begin
        t_r[m]   <= SIN_COEF[m] - p[60:30];
        x_r[m+2] <= x_r[m+1];
        n_r[m+2] <= n_r[m+1];
      end
    end
    if (m < 3) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) x2_r[m+1] <= x2_r[m];
      end
    end
  end

  assign sine = sine_r;
endmodule

>>> design/capsule_vertex_generator.sv
// Capsule vertex generator top level: config, dividers, sines and output stages.
//
// Takes one grid point (ring, column) per word and returns the vertex position,
// unit normal, texture coordinates and a status code for a UV capsule set by the
// cfg_ registers. One word is accepted every cycle while the result side does not
// stall. Each word passes through the bit-per-stage divider pipelines, then the
// eight-stage sine pipelines and three product/rounding stages; grid indices use
// GRID_BITS bits, capped at 10. A stall on the result side freezes the whole
// pipeline. Registers are to be written only while the block is empty; the block
// itself does not enforce this.
module capsule_vertex_generator #(
  parameter int GRID_BITS  = 10,
  parameter int ANGLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // ring_index[9:0], column_index[19:10]
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z (17 each), norm_x, norm_y, norm_z (16 each),
  // tex_u, tex_v (17 each), zero fill
  output logic [135:0] out_tdata,
  output logic [1:0]   out_tuser   // status
);
  import cvg_pkg::*;

  localparam int IW = (GRID_BITS < 10) ? GRID_BITS : 10;
  localparam int PW = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam int NW = IW + PW;
  localparam int SW = $bits(side_t);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [15:0] cap_height_r, cap_radius_r;
  logic [9:0]  column_count_r, ring_count_r;
  logic [15:0] hh_r;
  logic        pipe_en;

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_height_r   <= 16'd512;
      cap_radius_r   <= 16'd128;
      column_count_r <= 10'd16;
      ring_count_r   <= 10'd16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_HEIGHT:  cap_height_r   <= cfg_wdata;
        REG_RADIUS:  cap_radius_r   <= cfg_wdata;
        REG_COLUMNS: column_count_r <= cfg_wdata[9:0];
        REG_RINGS:   ring_count_r   <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  logic signed [17:0] h_full;
  assign h_full = $signed({2'b0, cap_height_r}) - $signed({1'b0, cap_radius_r, 1'b0});
  always_ff @(posedge clk) begin
    hh_r <= h_full[17] ? 16'd0 : h_full[16:1];
  end

  logic [IW-1:0] cols, rings;
  assign cols  = column_count_r[IW-1:0];
  assign rings = ring_count_r[IW-1:0];

  // ---------------- input decode
  logic [IW-1:0] ri, ci;
  side_t         side_in;
  assign ri = in_tdata[IW-1:0];
  assign ci = in_tdata[10 +: IW];

  always_comb begin
    side_in.plo = ri == '0;
    side_in.phi = ri == rings;
    side_in.bot = {ri, 1'b0} <= {1'b0, rings};
    if (cap_height_r == '0 || cap_radius_r == '0 || cols < IW'(3) || rings == '0)
      side_in.st = ST_BAD_CFG;
    else if (ri > rings || ci > cols)
      side_in.st = ST_OUT_OF_GRID;
    else
      side_in.st = ST_OK;
  end

  assign pipe_en   = !out_tvalid || out_tready;
  assign in_tready = pipe_en;

  // ---------------- dividers
  logic [NW-1:0] q_tu, q_tv, q_lat, q_lon;

  cvg_div #(.NW(NW), .DW(IW)) u_div_tu (
    .clk(clk), .en(pipe_en),
    .num((NW'(ci) << 16) + NW'(cols >> 1)), .den(cols), .quo(q_tu));
  cvg_div #(.NW(NW), .DW(IW)) u_div_lon (
    .clk(clk), .en(pipe_en),
    .num((NW'(ci) << ANGLE_BITS) + NW'(cols >> 1)), .den(cols), .quo(q_lon));
  cvg_div #(.NW(NW), .DW(IW)) u_div_lat (
    .clk(clk), .en(pipe_en),
    .num((NW'(ri) << (ANGLE_BITS - 1)) + NW'(rings >> 1)), .den(rings), .quo(q_lat));
  cvg_div #(.NW(NW), .DW(IW)) u_div_tv (
    .clk(clk), .en(pipe_en),
    .num((NW'(ri) << 15) + NW'(rings >> 1)), .den(rings), .quo(q_tv));

  logic [SW:0] dly_a;
  cvg_delay #(.W(SW + 1), .DEPTH(NW)) u_dly_a (
    .clk(clk), .rst_n(rst_n), .en(pipe_en),
    .din({in_tvalid, side_in}), .dout(dly_a));

  side_t       side_a;
  logic [16:0] tv_a;
  assign side_a = dly_a[SW-1:0];
  assign tv_a   = q_tv[16:0] + (side_a.bot ? 17'd0 : 17'd16384);

  // ---------------- sines
  logic [ANGLE_BITS-1:0] ph_lat, ph_lon;
  logic signed [31:0]    sl, cl, so, co;
  assign ph_lat = q_lat[ANGLE_BITS-1:0];
  assign ph_lon = q_lon[ANGLE_BITS-1:0];

  cvg_sine #(.AB(ANGLE_BITS)) u_sin_lat (
    .clk(clk), .en(pipe_en), .phase(ph_lat), .sine(sl));
  cvg_sine #(.AB(ANGLE_BITS)) u_cos_lat (
    .clk(clk), .en(pipe_en), .phase(ph_lat + QUARTER), .sine(cl));
  cvg_sine #(.AB(ANGLE_BITS)) u_sin_lon (
    .clk(clk), .en(pipe_en), .phase(ph_lon), .sine(so));
  cvg_sine #(.AB(ANGLE_BITS)) u_cos_lon (
    .clk(clk), .en(pipe_en), .phase(ph_lon + QUARTER), .sine(co));

  logic [SW+34:0] dly_b;
  cvg_delay #(.W(SW + 35), .DEPTH(SINE_LAT)) u_dly_b (
    .clk(clk), .rst_n(rst_n), .en(pipe_en),
    .din({dly_a[SW], side_a, q_tu[16:0], tv_a}), .dout(dly_b));

  // ---------------- product and rounding stages
  logic signed [16:0] r_s;
  assign r_s = $signed({1'b0, cap_radius_r});

  logic               v1_r, v2_r;
  side_t              s1_r, s2_r;
  logic [16:0]        tu1_r, tv1_r, tu2_r, tv2_r;
  logic signed [31:0] qx1_r, qz1_r;
  logic signed [17:0] pyr1_r;
  logic signed [15:0] ny1_r, nx2_r, ny2_r, nz2_r;
  logic signed [48:0] mpx2_r, mpz2_r;
  logic signed [16:0] py2_r;
  logic signed [63:0] py_wide;

  assign py_wide = s1_r.bot ? 64'(pyr1_r) - 64'(hh_r) : 64'(pyr1_r) + 64'(hh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= dly_b[SW+34];
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_r   <= dly_b[SW+33:34];
      tu1_r  <= dly_b[33:17];
      tv1_r  <= dly_b[16:0];
      qx1_r  <= 32'(rnd_away(64'(co) * 64'(sl), 30));
      qz1_r  <= 32'(rnd_away(64'(so) * 64'(sl), 30));
      pyr1_r <= 18'(rnd_away(64'(cl) * 64'(r_s), 30));
      ny1_r  <= 16'(rnd_away(64'(cl), 16));

      s2_r   <= s1_r;
      tu2_r  <= tu1_r;
      tv2_r  <= tv1_r;
      nx2_r  <= 16'(rnd_away(64'(qx1_r), 16));
      nz2_r  <= 16'(rnd_away(64'(qz1_r), 16));
      ny2_r  <= ny1_r;
      mpx2_r <= 49'(64'(qx1_r) * 64'(r_s));
      mpz2_r <= 49'(64'(qz1_r) * 64'(r_s));
      py2_r  <= sat17(py_wide);
    end
  end

  // ---------------- output register
  logic               out_tvalid_r;
  logic [135:0]       out_tdata_r, out_tdata_nxt;
  logic [1:0]         out_tuser_r;
  logic signed [16:0] px, py, pz, ptop;
  logic signed [15:0] nx, ny, nz;
  logic [16:0]        tu, tv;

  assign ptop = sat17(64'(hh_r) + 64'(cap_radius_r));

  always_comb begin
    px = sat17(rnd_away(64'(mpx2_r), 30));
    pz = sat17(rnd_away(64'(mpz2_r), 30));
    py = py2_r;
    nx = nx2_r;
    ny = ny2_r;
    nz = nz2_r;
    tu = tu2_r;
    tv = tv2_r;
    if (s2_r.st != ST_OK) begin
      px = '0; py = '0; pz = '0; nx = '0; ny = '0; nz = '0; tu = '0; tv = '0;
    end else if (s2_r.plo) begin
      px = '0; pz = '0; nx = '0; nz = '0;
      py = -ptop;
      ny = -16'sd16384;
      tv = '0;
    end else if (s2_r.phi) begin
      px = '0; pz = '0; nx = '0; nz = '0;
      py = ptop;
      ny = 16'sd16384;
      tv = 17'd65536;
    end
    out_tdata_nxt = {3'b0, tv, tu, nz, ny, nx, pz, py, px};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (pipe_en) begin
      out_tvalid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= s2_r.st;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("error word carries nonzero payload");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable({v1_r, v2_r, py2_r, qx1_r}))
    else $error("pipeline moved during stall");

  a_tex_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[115:99] <= 17'd65536)
    else $error("tex_u above one");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_OK || out_tuser == ST_BAD_CFG ||
                   out_tuser == ST_OUT_OF_GRID)
    else $error("status out of range");
endmodule

>>> tb/sv/cvg_checker.sv
// Checker for the capsule vertex generator: predicts each result and compares.
`timescale 1ns / 100ps
module cvg_checker
  import cvg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [23:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [16:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic [16:0] tu, tv;
    logic [1:0]  st;
  } vertex_t;

  logic [15:0] height_q, radius_q;
  logic [9:0]  cols_q, rings_q;
  vertex_t     vertex_q[$];

  function automatic longint round_away(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    return (v < 0) ? -((-v + half) >>> sh) : ((v + half) >>> sh);
  endfunction

  function automatic longint clip17(longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint unsigned div_near(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic longint sine_of(longint unsigned p);
    longint unsigned x, x2, t;
    logic [1:0] quad;
    p = p & 64'hFFFF;
    quad = p[15:14];
    x = longint'(p[13:0]) << 16;
    if (quad[0]) x = (longint'(1) << 30) - x;
    x2 = (x * x) >> 30;
    t = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    t = 64'd85569306 - ((x2 * t) >> 30);
    t = 64'd693598668 - ((x2 * t) >> 30);
    t = 64'd1686629713 - ((x2 * t) >> 30);
    t = (x * t) >> 30;
    if (t > (64'd1 << 30)) t = 64'd1 << 30;
    return quad[1] ? -longint'(t) : longint'(t);
  endfunction

  function automatic vertex_t vertex_at(logic [9:0] ring, logic [9:0] col);
    vertex_t v;
    longint r, h, hh, sl, cl, so, co, qx, qz, py;
    longint unsigned plat, plon;
    logic bottom;
    v = '0;
    r = radius_q;
    if (height_q == 0 || radius_q == 0 || cols_q < 3 || rings_q < 1) begin
      v.st = ST_BAD_CFG;
    end else if (ring > rings_q || col > cols_q) begin
      v.st = ST_OUT_OF_GRID;
    end else begin
      v.st = ST_OK;
      h = longint'(height_q) - 2 * r;
      hh = (h < 0) ? 0 : (h >>> 1);
      v.tu = 17'(div_near(longint'(col) << 16, cols_q));
      if (ring == 0) begin
        v.py = 17'(clip17(-(hh + r)));
        v.ny = -16'sd16384;
      end else if (ring == rings_q) begin
        v.py = 17'(clip17(hh + r));
        v.ny = 16'sd16384;
        v.tv = 17'd65536;
      end else begin
        plat = div_near(longint'(ring) << 15, rings_q);
        plon = div_near(longint'(col) << 16, cols_q);
        sl = sine_of(plat);
        cl = sine_of(plat + 16384);
        so = sine_of(plon);
        co = sine_of(plon + 16384);
        qx = round_away(co * sl, 30);
        qz = round_away(so * sl, 30);
        bottom = (2 * int'(ring)) <= int'(rings_q);
        v.nx = 16'(round_away(qx, 16));
        v.ny = 16'(round_away(cl, 16));
        v.nz = 16'(round_away(qz, 16));
        v.px = 17'(clip17(round_away(qx * r, 30)));
        v.pz = 17'(clip17(round_away(qz * r, 30)));
        py = round_away(cl * r, 30);
        v.py = 17'(clip17(bottom ? py - hh : py + hh));
        v.tv = 17'(div_near(longint'(ring) << 15, rings_q) + (bottom ? 0 : 16384));
      end
    end
    return v;
  endfunction

  task automatic report(string what, logic [16:0] got, logic [16:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst_n) begin
      height_q <= 16'd512;
      radius_q <= 16'd128;
      cols_q   <= 10'd16;
      rings_q  <= 10'd16;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_HEIGHT:  height_q <= cfg_wdata;
          REG_RADIUS:  radius_q <= cfg_wdata;
          REG_COLUMNS: cols_q   <= cfg_wdata[9:0];
          REG_RINGS:   rings_q  <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        vertex_q = {vertex_q, vertex_at(in_tdata[9:0], in_tdata[19:10])};
      if (out_tvalid && out_tready) begin
        got = {out_tdata[16:0], out_tdata[33:17], out_tdata[50:34], out_tdata[66:51],
               out_tdata[82:67], out_tdata[98:83], out_tdata[115:99],
               out_tdata[132:116], out_tuser};
        if (vertex_q.size() == 0) begin
          report("unexpected word", got.px, 17'd0);
        end else begin
          want = vertex_q.pop_front();
          if (got.px != want.px) report("pos_x", got.px, want.px);
          if (got.py != want.py) report("pos_y", got.py, want.py);
          if (got.pz != want.pz) report("pos_z", got.pz, want.pz);
          if (got.nx != want.nx) report("norm_x", 17'(got.nx), 17'(want.nx));
          if (got.ny != want.ny) report("norm_y", 17'(got.ny), 17'(want.ny));
          if (got.nz != want.nz) report("norm_z", 17'(got.nz), 17'(want.nz));
          if (got.tu != want.tu) report("tex_u", got.tu, want.tu);
          if (got.tv != want.tv) report("tex_v", got.tv, want.tv);
          if (got.st != want.st) report("status", 17'(got.st), 17'(want.st));
        end
      end
    end
    pending = vertex_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the capsule vertex generator testbench: clock, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
  import cvg_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic [1:0]   cfg_index = REG_HEIGHT;
  logic [15:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;
  int           errors, pending;
  logic [9:0]   cols_now = 10'd16, rings_now = 10'd16;
  bit           sender_calm = 1'b0, sink_calm = 1'b0;
  int           sink_wait = 0;
  int           idle_cycles = 0;

  always #2 clk = ~clk;

  capsule_vertex_generator dut (.*);

  cvg_checker checker_i (.*);

  // result side: random stall between words, none while sink_calm is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      sink_wait = sink_calm ? 0 : $urandom_range(0, 11);
      out_tready <= (sink_wait == 0);
    end else if (sink_wait > 0) begin
      sink_wait--;
      out_tready <= (sink_wait == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_point(logic [9:0] ring, logic [9:0] col);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, col, ring};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_shape(logic [15:0] h, logic [15:0] r, logic [9:0] c, logic [9:0] g);
    logic [15:0] vals[4];
    vals = '{h, r, {6'd0, c}, {6'd0, g}};
    cfg_wr_en <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= 2'(k);
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cols_now = c;
    rings_now = g;
  endtask

  task automatic random_points(int n);
    int pick;
    logic [9:0] ring, col;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 9);
      ring = 10'($urandom_range(0, rings_now));
      col = 10'($urandom_range(0, cols_now));
      if (pick == 0) ring = ($urandom_range(0, 1) != 0) ? rings_now : 10'd0;
      if (pick >= 8) begin
        ring = 10'($urandom);
        col = 10'($urandom);
      end
      send_point(ring, col);
    end
  endtask

  initial begin
    logic [15:0] h, r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed at reset settings: poles, edges, hemisphere boundary, out of grid
    send_point(10'd0, 10'd0);
    send_point(10'd16, 10'd16);
    send_point(10'd0, 10'd7);
    send_point(10'd1, 10'd0);
    send_point(10'd8, 10'd4);
    send_point(10'd9, 10'd4);
    send_point(10'd15, 10'd15);
    send_point(10'd8, 10'd16);
    send_point(10'd17, 10'd0);
    send_point(10'd0, 10'd17);
    send_point(10'h3FF, 10'h3FF);
    send_point(10'h155, 10'h2AA);
    send_point(10'h2AA, 10'h155);
    drain();

    // odd ring count puts the equator between rows
    load_shape(16'd700, 16'd300, 10'd5, 10'd5);
    for (int k = 0; k <= 5; k++) send_point(10'(k), 10'(k));
    drain();

    load_shape(16'd0, 16'd128, 10'd16, 10'd16);   random_points(40);  drain();
    load_shape(16'd512, 16'd0, 10'd16, 10'd16);   random_points(40);  drain();
    load_shape(16'd512, 16'd128, 10'd2, 10'd16);  random_points(40);  drain();
    load_shape(16'd512, 16'd128, 10'd16, 10'd0);  random_points(40);  drain();
    load_shape(16'd512, 16'd128, 10'd3, 10'd1);   random_points(60);  drain();
    load_shape(16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF);
    sender_calm = 1'b1; sink_calm = 1'b1;
    random_points(150);
    drain();
    sender_calm = 1'b0; sink_calm = 1'b0;
    load_shape(16'hFFFF, 16'd1, 10'd3, 10'd2);    random_points(60);  drain();
    load_shape(16'd100, 16'd200, 10'd7, 10'd5);   random_points(80);  drain();
    load_shape(16'd1, 16'hFFFF, 10'h3FF, 10'd1);  random_points(60);  drain();
    sink_calm = 1'b1;
    load_shape(16'd512, 16'd128, 10'd16, 10'd16); random_points(100); drain();
    sink_calm = 1'b0;
    for (int p = 0; p < 6; p++) begin
      h = 16'($urandom);
      r = 16'($urandom);
      if (p[0]) r = r >> $urandom_range(0, 15);
      sender_calm = (p == 2);
      load_shape(h, r, 10'($urandom_range(3, 64)), 10'($urandom_range(1, 64)));
      random_points(80);
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
